// ===== sv/cas_pkg.sv =====
package cas_pkg;

  // Window geometry and field widths.
  localparam int unsigned DEPTH         = 32;
  localparam int unsigned PTR_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned LIMIT_W       = 6;
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned DEFAULT_LIMIT = 32;

  // Request codes carried in req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD     = 2'd0,
    REQ_REFRESH = 2'd1,
    REQ_CLEAR   = 2'd2
  } cas_req_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LIMIT = 1'b0,
    CFG_AGE_LIMIT    = 1'b1
  } cas_cfg_e;

  // Event kinds reported on the output channel.
  typedef enum logic {
    EVT_REMOVE = 1'b0,
    EVT_ADD    = 1'b1
  } cas_evt_e;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_COUNT,
    ST_CLEAR,
    ST_DONE
  } cas_state_e;

  // One window entry as held in memory.
  typedef struct packed {
    logic [TIME_W-1:0] push_time;
    logic [DATA_W-1:0] value;
  } cas_entry_t;

  // One event word before the last flag is attached.
  typedef struct packed {
    logic              event_kind;
    logic [DATA_W-1:0] event_value;
    logic [CNT_W-1:0]  entries_after;
  } cas_word_t;

  // Commands from the sequencer to the event stage.
  typedef struct packed {
    logic push;
    logic flush;
  } cas_stg_ctrl_t;

  // Zero selects the default limit; anything above the depth saturates.
  function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] wl);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(wl);
    if (lim == '0) lim = CNT_W'(DEFAULT_LIMIT);
    if (lim > CNT_W'(DEPTH)) lim = CNT_W'(DEPTH);
    return lim;
  endfunction

  // Circular pointer advance.
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== sv/cas_req_if.sv =====
interface cas_req_if;
  import cas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] value;
  logic [TIME_W-1:0]        now_ticks;

  modport source (output valid, req_type, value, now_ticks, input ready);
  modport sink   (input valid, req_type, value, now_ticks, output ready);
endinterface

// ===== sv/cas_evt_if.sv =====
interface cas_evt_if;
  import cas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     event_kind;
  logic signed [DATA_W-1:0] event_value;
  logic [CNT_W-1:0]         entries_after;
  logic                     last;

  modport source (output valid, event_kind, event_value, entries_after, last, input ready);
  modport sink   (input valid, event_kind, event_value, entries_after, last, output ready);
endinterface

// ===== sv/cas_evt_stage.sv =====
// Event staging: one pending word plus the output register. A word waits in
// the pending slot until either the next word of the same request arrives
// (then it leaves with last clear) or the request is flushed (last set).
module cas_evt_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cas_pkg::cas_stg_ctrl_t ctrl_i,
  input  cas_pkg::cas_word_t     word_i,
  output logic                   rdy_o,
  cas_evt_if.source              evt_o
);
  import cas_pkg::*;

  logic      out_v_q;
  logic      pend_v_q;
  cas_word_t pend_q;
  cas_word_t out_q;
  logic      out_last_q;
  logic      out_free;
  logic      load_out;

  // The pending word can move on whenever the output register is free.
  assign out_free = !out_v_q || evt_o.ready;
  assign rdy_o    = !pend_v_q || out_free;
  assign load_out = rdy_o && pend_v_q && (ctrl_i.push || ctrl_i.flush);

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (evt_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (rdy_o && ctrl_i.push) begin
        pend_v_q <= 1'b1;
      end else if (rdy_o && ctrl_i.flush) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q      <= pend_q;
      out_last_q <= ctrl_i.flush;
    end
    if (rdy_o && ctrl_i.push) begin
      pend_q <= word_i;
    end
  end

  // Output channel.
  assign evt_o.valid         = out_v_q;
  assign evt_o.event_kind    = out_q.event_kind;
  assign evt_o.event_value   = out_q.event_value;
  assign evt_o.entries_after = out_q.entries_after;
  assign evt_o.last          = out_last_q;

endmodule

// ===== sv/count_and_age_sliding_window.sv =====
// Channel   Dir  Handshake       Word
// req_i     in   valid / ready   req_type, value, now_ticks
// evt_o     out  valid / ready   event_kind, event_value, entries_after, last
// cfg       in   cfg_we_i        cfg_idx_i selects the register, cfg_data_i
//
// One request at a time. A request runs the age pass (add and refresh, when
// age_limit is nonzero), then the count pass or the clear pass, then done.
// An ignored request code goes straight to done and produces no word.
// Each pass loops on the head read, compare and pointer update, one memory
// read per cycle at the next head address while the output is not stalled.
// Reset clears pointers, count and the sequencer; the entry memory is not
// cleared, and only occupied entries are ever reported.
// A stalled output holds the sequencer in place; one word waits in a pending
// slot so the last flag can be attached when the request ends.
module count_and_age_sliding_window (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cas_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cas_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  cas_req_if.sink                         req_i,
  cas_evt_if.source                       evt_o
);
  import cas_pkg::*;

  cas_state_e        state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  lim_q;
  logic [TIME_W-1:0] age_lim_q;
  logic              is_add_q;
  logic [DATA_W-1:0] val_q;
  logic [TIME_W-1:0] now_q;
  cas_entry_t        rd_q;
  cas_entry_t        entry_mem [DEPTH];

  cas_stg_ctrl_t     stg_ctrl;
  cas_word_t         stg_word;
  logic              stg_rdy;
  logic              req_acc;
  logic              evict;
  logic              add_now;
  logic              wr_en;
  cas_entry_t        wr_entry;
  logic [TIME_W-1:0] age;
  logic              age_expired;
  logic              count_full;

  // Configuration writes; the window limit is stored already resolved.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q     <= eff_limit(LIMIT_W'(DEFAULT_LIMIT));
      age_lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cas_cfg_e'(cfg_idx_i))
        CFG_WINDOW_LIMIT: lim_q     <= eff_limit(cfg_data_i[LIMIT_W-1:0]);
        CFG_AGE_LIMIT:    age_lim_q <= cfg_data_i[TIME_W-1:0];
      endcase
    end
  end

  // Eviction tests on the head entry, which rd_q always holds.
  assign age         = now_q - rd_q.push_time;
  assign age_expired = (age >= age_lim_q);
  assign count_full  = (count_q != '0) && (count_q >= lim_q);

  assign req_acc = req_i.valid && req_i.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE, ST_DONE: begin
        if (req_acc) begin
          unique case (cas_req_e'(req_i.req_type))
            REQ_ADD, REQ_REFRESH: state_d = (age_lim_q != '0) ? ST_AGE : ST_COUNT;
            REQ_CLEAR:            state_d = ST_CLEAR;
            default:              state_d = ST_DONE;
          endcase
        end else if (state_q == ST_DONE && stg_rdy) begin
          state_d = ST_IDLE;
        end
      end
      ST_AGE: begin
        if (!evict) state_d = ST_COUNT;
      end
      ST_COUNT: begin
        if (!evict && (!is_add_q || stg_rdy)) state_d = ST_DONE;
      end
      ST_CLEAR: begin
        if (count_q == '0) state_d = ST_DONE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    evict          = 1'b0;
    add_now        = 1'b0;
    stg_ctrl.flush = 1'b0;
    req_i.ready    = 1'b0;
    unique case (state_q)
      ST_IDLE:  req_i.ready = 1'b1;
      ST_AGE:   evict = (count_q != '0) && age_expired;
      ST_COUNT: begin
        evict   = count_full;
        add_now = !count_full && is_add_q;
      end
      ST_CLEAR: evict = (count_q != '0);
      ST_DONE: begin
        stg_ctrl.flush = 1'b1;
        req_i.ready    = stg_rdy;
      end
      default: ;
    endcase
    stg_ctrl.push = evict || add_now;
  end

  // Pointer and count updates for the event taken this cycle.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    count_d = count_q;
    wr_en = 1'b0;
    if (evict && stg_rdy) begin
      head_d  = next_ptr(head_q);
      count_d = count_q - 1'b1;
    end else if (add_now && stg_rdy) begin
      tail_d  = next_ptr(tail_q);
      count_d = count_q + 1'b1;
      wr_en   = 1'b1;
    end
  end

  assign wr_entry.push_time = now_q;
  assign wr_entry.value     = val_q;

  assign stg_word.event_kind    = add_now ? EVT_ADD : EVT_REMOVE;
  assign stg_word.event_value   = add_now ? val_q : rd_q.value;
  assign stg_word.entries_after = count_d;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Request word capture.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      is_add_q <= (cas_req_e'(req_i.req_type) == REQ_ADD);
      val_q    <= req_i.value;
      now_q    <= req_i.now_ticks;
    end
  end

  // Entry memory: written at the tail, read at the next head address, with
  // the write data forwarded when both land on the same entry.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[tail_q] <= wr_entry;
    end
    if (wr_en && (tail_q == head_d)) begin
      rd_q <= wr_entry;
    end else begin
      rd_q <= entry_mem[head_d];
    end
  end

  cas_evt_stage u_evt_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (stg_ctrl),
    .word_i (stg_word),
    .rdy_o  (stg_rdy),
    .evt_o  (evt_o)
  );

`ifndef SYNTHESIS
  // The window never holds more entries than the memory has.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // A removal is only ever taken from an occupied window.
  a_evict_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evict && stg_rdy) |-> (count_q != '0))
    else $error("removal from empty window");

  // An add grows the window by exactly one entry.
  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (add_now && stg_rdy) |=> (count_q == $past(count_q) + 1'b1))
    else $error("add did not advance the count");
`endif

endmodule

// ===== dv/tb_count_and_age_sliding_window.sv =====
`timescale 1ns / 100ps

module tb_count_and_age_sliding_window;
  import cas_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS     = 30;

  // One expected event word.
  typedef struct packed {
    cas_evt_e          kind;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic              last;
  } window_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cas_req_if req_ch ();
  cas_evt_if evt_ch ();

  count_and_age_sliding_window uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .evt_o      (evt_ch)
  );

  always #2 clk_i = ~clk_i;

  // Our own copy of the window and its settings.
  logic [DATA_W-1:0]  win_value [DEPTH];
  logic [TIME_W-1:0]  win_time [DEPTH];
  logic [PTR_W-1:0]   win_head;
  logic [PTR_W-1:0]   win_tail;
  logic [CNT_W-1:0]   win_count;
  logic [LIMIT_W-1:0] cur_window_limit;
  logic [TIME_W-1:0]  cur_age_limit;

  window_event_t events_due[$];
  int error_count;
  int tx_idle_pct;
  int rx_stall_pct;
  int quiet_cycles;
  logic [TIME_W-1:0] tick_now;

  function automatic logic [PTR_W-1:0] advance_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  task automatic note_event(input cas_evt_e kind, input logic [DATA_W-1:0] val);
    window_event_t w;
    w.kind  = kind;
    w.value = val;
    w.count = win_count;
    w.last  = 1'b0;
    events_due.push_back(w);
  endtask

  task automatic drop_oldest_entry();
    logic [DATA_W-1:0] v;
    v = win_value[win_head];
    win_head = advance_slot(win_head);
    win_count = win_count - 1'b1;
    note_event(EVT_REMOVE, v);
  endtask

  // Age pass first, then the count pass down to one below the limit.
  task automatic evict_stale_and_excess(input logic [TIME_W-1:0] now);
    logic [CNT_W-1:0] lim;
    if (cur_age_limit != '0) begin
      while (win_count != '0 &&
             TIME_W'(now - win_time[win_head]) >= cur_age_limit)
        drop_oldest_entry();
    end
    lim = CNT_W'(cur_window_limit);
    if (lim == '0) lim = CNT_W'(DEFAULT_LIMIT);
    if (lim > CNT_W'(DEPTH)) lim = CNT_W'(DEPTH);
    while (win_count != '0 && win_count >= lim)
      drop_oldest_entry();
  endtask

  // Work out every event word that one accepted request causes.
  task automatic update_window(input logic [REQ_W-1:0] kind,
                               input logic [DATA_W-1:0] val,
                               input logic [TIME_W-1:0] now);
    int first;
    window_event_t final_word;
    first = events_due.size();
    case (kind)
      REQ_ADD: begin
        evict_stale_and_excess(now);
        win_value[win_tail] = val;
        win_time[win_tail]  = now;
        win_tail  = advance_slot(win_tail);
        win_count = win_count + 1'b1;
        note_event(EVT_ADD, val);
      end
      REQ_REFRESH: begin
        evict_stale_and_excess(now);
      end
      REQ_CLEAR: begin
        while (win_count != '0) drop_oldest_entry();
      end
      default: begin
      end
    endcase
    if (events_due.size() > first) begin
      final_word = events_due.pop_back();
      final_word.last = 1'b1;
      events_due.push_back(final_word);
    end
  endtask

  // Drive one request and hold it until the block takes it.
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [DATA_W-1:0] val,
                              input logic [TIME_W-1:0] now);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid     = 1'b1;
    req_ch.req_type  = kind;
    req_ch.value     = val;
    req_ch.now_ticks = now;
    do @(posedge clk_i); while (!req_ch.ready);
    update_window(kind, val, now);
  endtask

  // Let every outstanding word arrive and the sequencer fall idle.
  task automatic wait_for_idle();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input cas_cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    wait_for_idle();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_WINDOW_LIMIT: cur_window_limit = data[LIMIT_W-1:0];
      CFG_AGE_LIMIT:    cur_age_limit = data;
      default: begin
      end
    endcase
  endtask

  // Mostly a forward-moving clock with random steps; some requests carry a wild time.
  task automatic run_random_requests(input int count, input int add_pct,
                                     input int clear_pct);
    int roll;
    int unsigned step_max;
    logic [REQ_W-1:0] kind;
    logic [TIME_W-1:0] stamp;
    step_max = (cur_age_limit == '0 || cur_age_limit > 32'd3000) ?
               1000 : cur_age_limit / 3 + 1;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < clear_pct) kind = REQ_CLEAR;
      else if (roll < clear_pct + 3) kind = REQ_UNUSED;
      else if (roll < clear_pct + 3 + add_pct) kind = REQ_ADD;
      else kind = REQ_REFRESH;
      if ($urandom_range(0, 9) == 0) begin
        stamp = $urandom();
      end else begin
        tick_now = tick_now + $urandom_range(0, step_max);
        stamp = tick_now;
      end
      send_request(kind, $urandom(), stamp);
    end
  endtask

  // Extreme values, every request code and the ignored one, on the default setup.
  task automatic test_basic_requests();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_request(REQ_ADD, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(REQ_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'h0000_0000, 32'h0000_0001);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 32'h0000_0002);
    send_request(REQ_REFRESH, $urandom(), 32'h0000_0003);
    send_request(REQ_UNUSED, $urandom(), 32'h0000_0004);
    send_request(REQ_CLEAR, $urandom(), 32'h0000_0005);
    send_request(REQ_CLEAR, $urandom(), 32'h0000_0006);
  endtask

  // Smallest limit, refresh while full, and a limit lowered under a full window.
  task automatic test_count_limit();
    write_register(CFG_WINDOW_LIMIT, 32'd1);
    send_request(REQ_ADD, $urandom(), 32'd10);
    send_request(REQ_ADD, $urandom(), 32'd11);
    send_request(REQ_REFRESH, $urandom(), 32'd12);
    write_register(CFG_WINDOW_LIMIT, 32'd4);
    repeat (4) send_request(REQ_ADD, $urandom(), 32'd13);
    write_register(CFG_WINDOW_LIMIT, 32'd2);
    send_request(REQ_REFRESH, $urandom(), 32'd14);
    send_request(REQ_ADD, $urandom(), 32'd15);
    send_request(REQ_CLEAR, $urandom(), 32'd16);
  endtask

  // Expiry exactly at the limit, and ages measured across the time wrap.
  task automatic test_age_expiry();
    write_register(CFG_WINDOW_LIMIT, 32'd32);
    write_register(CFG_AGE_LIMIT, 32'd10);
    send_request(REQ_ADD, $urandom(), 32'd100);
    send_request(REQ_ADD, $urandom(), 32'd105);
    send_request(REQ_REFRESH, $urandom(), 32'd110);
    send_request(REQ_ADD, $urandom(), 32'hFFFF_FFFE);
    send_request(REQ_REFRESH, $urandom(), 32'd5);
    send_request(REQ_REFRESH, $urandom(), 32'd8);
    send_request(REQ_ADD, $urandom(), 32'd9);
  endtask

  // Zero limit means the full depth; mostly adds so the window fills up.
  task automatic test_random_fill();
    write_register(CFG_WINDOW_LIMIT, 32'd0);
    write_register(CFG_AGE_LIMIT, 32'd0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_random_requests(100, 75, 1);
  endtask

  // Oversized limit saturates to the depth; the largest age limit.
  task automatic test_random_sender_idle();
    write_register(CFG_WINDOW_LIMIT, 32'd63);
    write_register(CFG_AGE_LIMIT, 32'hFFFF_FFFF);
    tx_idle_pct  = 87;
    rx_stall_pct = 0;
    run_random_requests(80, 65, 4);
  endtask

  task automatic test_random_receiver_stall();
    write_register(CFG_WINDOW_LIMIT, 32'd5);
    write_register(CFG_AGE_LIMIT, 32'd1000);
    tx_idle_pct  = 0;
    rx_stall_pct = 87;
    run_random_requests(80, 60, 5);
  endtask

  // Random settings; unused upper bits of the limit write carry random values too.
  task automatic test_random_both_idle();
    write_register(CFG_WINDOW_LIMIT,
                   ($urandom() & 32'hFFFF_FFC0) | 32'($urandom_range(1, 32)));
    write_register(CFG_AGE_LIMIT, 32'($urandom_range(1, 200)));
    tx_idle_pct  = 26;
    rx_stall_pct = 26;
    run_random_requests(90, 60, 4);
  endtask

  // One entry kept and anything older than the current tick expires.
  task automatic test_random_tight();
    write_register(CFG_WINDOW_LIMIT, 32'd1);
    write_register(CFG_AGE_LIMIT, 32'd1);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_random_requests(60, 60, 5);
  endtask

  // Receiver ready, redrawn every cycle.
  initial begin
    evt_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      evt_ch.ready = ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Compare each delivered word with the oldest one due.
  always @(posedge clk_i) begin
    window_event_t want;
    if (rst_ni && evt_ch.valid && evt_ch.ready) begin
      if (events_due.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, got kind %0d value %h count %0d last %0b",
                   $time, evt_ch.event_kind, evt_ch.event_value, evt_ch.entries_after,
                   evt_ch.last);
      end else begin
        want = events_due.pop_front();
        if (evt_ch.event_kind !== want.kind || evt_ch.event_value !== want.value ||
            evt_ch.entries_after !== want.count || evt_ch.last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"%0t: mismatch, expected kind %0d value %h count %0d last %0b,",
                      " got kind %0d value %h count %0d last %0b"},
                     $time, want.kind, want.value, want.count, want.last,
                     evt_ch.event_kind, evt_ch.event_value, evt_ch.entries_after,
                     evt_ch.last);
        end
      end
    end
  end

  // Ends a run that stops making progress.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (evt_ch.valid && evt_ch.ready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_count_and_age_sliding_window NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_WINDOW_LIMIT;
    cfg_data_i       = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_ADD;
    req_ch.value     = '0;
    req_ch.now_ticks = '0;
    win_head         = '0;
    win_tail         = '0;
    win_count        = '0;
    cur_window_limit = LIMIT_W'(DEFAULT_LIMIT);
    cur_age_limit    = '0;
    error_count      = 0;
    quiet_cycles     = 0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    tick_now         = 32'hFFFF_F000;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_requests();
    test_count_limit();
    test_age_expiry();
    test_random_fill();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_random_tight();

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("tb_count_and_age_sliding_window OK");
    else
      $display("tb_count_and_age_sliding_window NOT OK");
    $finish;
  end

endmodule
